// ===== hdl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the bit timing calculator.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

// ===== hdl/cbtc_pkg.sv =====
// ---------------------------------------------------------------------------
// cbtc_pkg
// Types, constants and helpers shared by the bit timing calculator.
// ---------------------------------------------------------------------------
package cbtc_pkg;

	localparam int unsigned DIV_W      = 32;
	localparam int unsigned CNT_W      = $clog2(DIV_W);
	localparam int unsigned Q_W        = 5;
	localparam int unsigned MAX_QUANTA = 25;
	localparam int unsigned MIN_QUANTA = 4;
	localparam int unsigned SYNC_Q     = 3;
	localparam int unsigned PRE_MAX    = 63;

	typedef enum logic [1:0] {
		DIV_HALF,
		DIV_REM,
		DIV_PRE
	} div_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CHECK,
		ST_HALF,
		ST_HALF_WAIT,
		ST_TRY,
		ST_TRY_WAIT,
		ST_PRE,
		ST_PRE_WAIT,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic    load;
		logic    clear;
		logic    div_start;
		div_op_t op;
		logic    take_half;
		logic    take_rem;
		logic    take_pre;
	} cmd_t;

	typedef struct packed {
		logic zero_in;
		logic div_done;
		logic rem_zero;
		logic count_last;
	} sts_t;

	// x / 3 for x in 0..22, as multiply by 11 and shift by 5
	function automatic logic [2:0] div3(input logic [Q_W-1:0] x);
		logic [Q_W+3:0] p;
		p = {4'b0, x} * (Q_W+4)'(11);
		return p[7:5];
	endfunction

endpackage

// ===== hdl/cbtc_div.sv =====
// ---------------------------------------------------------------------------
// cbtc_div
// Restoring serial divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbtc_div import cbtc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic             done,
	output logic [DIV_W-1:0] quotient,
	output logic [DIV_W-1:0] remainder
);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] div_q;

	logic [DIV_W:0]   shifted;
	logic [DIV_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, div_q};
	assign ge      = (shifted >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

	`ASSERT_IMPLIES(a_no_restart, clk, arst_n, start, !busy_q)
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done_q, !done_q)
	`ASSERT_IMPLIES(a_rem_below_div, clk, arst_n, done_q, rem_q < div_q)

endmodule

// ===== hdl/cbtc_dpath.sv =====
// ---------------------------------------------------------------------------
// cbtc_dpath
// Operand registers, candidate tracking and result formatting.
// ---------------------------------------------------------------------------
module cbtc_dpath import cbtc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [DIV_W-1:0] source_clock,
	input  logic [DIV_W-1:0] bit_rate,
	output logic             result_valid,
	output logic             no_fit,
	output logic             prescaler_out_of_range,
	output logic [Q_W-1:0]   chosen_quanta,
	output logic [5:0]       prescaler_value,
	output logic [3:0]       phase_segment_one,
	output logic [2:0]       phase_segment_two
);

	logic [DIV_W-1:0] clk_q;
	logic [DIV_W-1:0] rate_q;
	logic [DIV_W-2:0] half_q;
	logic [Q_W-1:0]   count_q;
	logic [Q_W-1:0]   chosen_q;
	logic [DIV_W-1:0] best_q;

	logic             valid_q;
	logic             nofit_q;
	logic             range_q;
	logic [Q_W-1:0]   quanta_q;
	logic [5:0]       pre_q;
	logic [3:0]       seg1_q;
	logic [2:0]       seg2_q;

	logic [DIV_W-1:0] dividend;
	logic [DIV_W-1:0] divisor;
	logic             div_done;
	logic [DIV_W-1:0] quotient;
	logic [DIV_W-1:0] remainder;

	logic [Q_W-1:0]   span;
	logic [2:0]       seg2;
	logic [Q_W-1:0]   seg1;

	always_comb begin
		case (cmd.op)
			DIV_HALF: begin
				dividend = clk_q;
				divisor  = rate_q;
			end
			DIV_REM: begin
				dividend = {1'b0, half_q};
				divisor  = DIV_W'(count_q);
			end
			DIV_PRE: begin
				dividend = {1'b0, half_q};
				divisor  = (chosen_q == '0) ? DIV_W'(1) : DIV_W'(chosen_q);
			end
			default: begin
				dividend = clk_q;
				divisor  = rate_q;
			end
		endcase
	end

	cbtc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (dividend),
		.divisor   (divisor),
		.done      (div_done),
		.quotient  (quotient),
		.remainder (remainder)
	);

	assign sts.zero_in    = (clk_q == '0) || (rate_q == '0);
	assign sts.div_done   = div_done;
	assign sts.rem_zero   = (remainder == '0);
	assign sts.count_last = (count_q == Q_W'(MIN_QUANTA));

	assign span = chosen_q - Q_W'(SYNC_Q);
	assign seg2 = div3(span);
	assign seg1 = span - Q_W'(seg2);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			clk_q  <= source_clock;
			rate_q <= bit_rate;
		end
		if (cmd.take_half) begin
			half_q   <= quotient[DIV_W-1:1];
			count_q  <= Q_W'(MAX_QUANTA);
			best_q   <= rate_q;
			chosen_q <= '0;
		end
		if (cmd.take_rem) begin
			count_q <= count_q - Q_W'(1);
			if (remainder == '0) begin
				chosen_q <= count_q;
			end else if (remainder < best_q) begin
				best_q   <= remainder;
				chosen_q <= count_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clear) begin
			valid_q  <= 1'b0;
			nofit_q  <= 1'b0;
			range_q  <= 1'b0;
			quanta_q <= '0;
			pre_q    <= '0;
			seg1_q   <= '0;
			seg2_q   <= '0;
		end else if (cmd.take_pre) begin
			valid_q  <= 1'b1;
			nofit_q  <= (chosen_q == '0);
			quanta_q <= chosen_q;
			if (quotient == '0) begin
				pre_q   <= '0;
				range_q <= 1'b1;
			end else if (quotient > DIV_W'(PRE_MAX + 1)) begin
				pre_q   <= 6'(PRE_MAX);
				range_q <= 1'b1;
			end else begin
				pre_q   <= 6'(quotient - DIV_W'(1));
				range_q <= 1'b0;
			end
			if (chosen_q == '0) begin
				seg1_q <= '0;
				seg2_q <= '0;
			end else begin
				seg1_q <= seg1[3:0];
				seg2_q <= seg2;
			end
		end
	end

	assign result_valid           = valid_q;
	assign no_fit                 = nofit_q;
	assign prescaler_out_of_range = range_q;
	assign chosen_quanta          = quanta_q;
	assign prescaler_value        = pre_q;
	assign phase_segment_one      = seg1_q;
	assign phase_segment_two      = seg2_q;

endmodule

// ===== hdl/cbtc_ctrl.sv =====
// ---------------------------------------------------------------------------
// cbtc_ctrl
// Sequencer: half rate, quanta search, prescaler, result strobe.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cbtc_ctrl import cbtc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output cmd_t cmd,
	input  sts_t sts
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.op  = DIV_HALF;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.zero_in) begin
					cmd.clear = 1'b1;
					state_d   = ST_EMIT;
				end else begin
					state_d = ST_HALF;
				end
			end
			ST_HALF: begin
				cmd.op        = DIV_HALF;
				cmd.div_start = 1'b1;
				state_d       = ST_HALF_WAIT;
			end
			ST_HALF_WAIT: begin
				if (sts.div_done) begin
					cmd.take_half = 1'b1;
					state_d       = ST_TRY;
				end
			end
			ST_TRY: begin
				cmd.op        = DIV_REM;
				cmd.div_start = 1'b1;
				state_d       = ST_TRY_WAIT;
			end
			ST_TRY_WAIT: begin
				if (sts.div_done) begin
					cmd.take_rem = 1'b1;
					// exact divisor ends the search early
					if (sts.rem_zero || sts.count_last) begin
						state_d = ST_PRE;
					end else begin
						state_d = ST_TRY;
					end
				end
			end
			ST_PRE: begin
				cmd.op        = DIV_PRE;
				cmd.div_start = 1'b1;
				state_d       = ST_PRE_WAIT;
			end
			ST_PRE_WAIT: begin
				cmd.op = DIV_PRE;
				if (sts.div_done) begin
					cmd.take_pre = 1'b1;
					state_d      = ST_EMIT;
				end
			end
			ST_EMIT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_EMIT);

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	`ASSERT_NEXT(a_done_release, clk, arst_n, done, !busy)
	`ASSERT_IMPLIES(a_div_idle_emit, clk, arst_n, done, !sts.div_done)

endmodule

// ===== hdl/can_bit_timing_calculator.sv =====
// ---------------------------------------------------------------------------
// can_bit_timing_calculator
// CAN bit timing search: prescaler and phase segments from clock and rate.
// ---------------------------------------------------------------------------
// Usage:
//   Drive source_clock and bit_rate and pulse start while busy is low; the
//   transaction is taken at that edge and busy stays high until the result
//   has been shown. The result fields appear together with done, high for
//   exactly one cycle; they stay on the ports until the next result.
//   When either input is zero the search is skipped and a cleared result
//   is shown. Otherwise quanta counts are tried from 25 down to 4, 1 to 22
//   of them. A new transaction is taken only when the last one is done.
//   Each division (clock/rate, one per tried count, and the prescaler
//   quotient) runs 32 steps on one shared serial restoring divider, with a
//   start and done handoff to the sequencer.
//   Reset returns the sequencer to idle and drops busy and done; any
//   transaction in flight is dropped.
//   The receiver cannot stall: a result not taken with done is kept only until the next result.
// ---------------------------------------------------------------------------
module can_bit_timing_calculator import cbtc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output logic             done,
	input  logic [DIV_W-1:0] source_clock,
	input  logic [DIV_W-1:0] bit_rate,
	output logic             result_valid,
	output logic             no_fit,
	output logic             prescaler_out_of_range,
	output logic [Q_W-1:0]   chosen_quanta,
	output logic [5:0]       prescaler_value,
	output logic [3:0]       phase_segment_one,
	output logic [2:0]       phase_segment_two
);

	cmd_t cmd;
	sts_t sts;

	cbtc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	cbtc_dpath u_dpath (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.cmd                    (cmd),
		.sts                    (sts),
		.source_clock           (source_clock),
		.bit_rate               (bit_rate),
		.result_valid           (result_valid),
		.no_fit                 (no_fit),
		.prescaler_out_of_range (prescaler_out_of_range),
		.chosen_quanta          (chosen_quanta),
		.prescaler_value        (prescaler_value),
		.phase_segment_one      (phase_segment_one),
		.phase_segment_two      (phase_segment_two)
	);

endmodule

// ===== bench/can_bit_timing_calculator_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// can_bit_timing_calculator_tb
// Drives clock/rate pairs into the bit timing search and checks each result
// against a local prediction of the quanta search, prescaler and segments.
// ---------------------------------------------------------------------------
module can_bit_timing_calculator_tb;
	import cbtc_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 560;
	localparam int unsigned N_DIRECTED   = 23;
	localparam int unsigned QUIET_TAIL   = 60;
	localparam int unsigned DRAIN_AT     = N_DIRECTED + 250;
	localparam int unsigned CYCLE_LIMIT  = 2_500_000;

	localparam logic [63:0] DIRECTED [N_DIRECTED] = '{
		{32'd0, 32'd0},
		{32'd0, 32'd500_000},
		{32'd80_000_000, 32'd0},
		{32'hFFFF_FFFF, 32'hFFFF_FFFF},
		{32'd1, 32'hFFFF_FFFF},
		{32'hFFFF_FFFF, 32'd1},
		{32'd8_000_000, 32'd500_000},
		{32'd80_000_000, 32'd1_000_000},
		{32'd16_000_000, 32'd125_000},
		{32'd48_000_000, 32'd1_000_000},
		{32'd8, 32'd1},
		{32'd3200, 32'd1},
		{32'd3250, 32'd1},
		{32'd58, 32'd1},
		{32'd202, 32'd1},
		{32'd2, 32'd1},
		{32'd116, 32'd2},
		{32'd162, 32'd3},
		{32'd10, 32'd3},
		{32'h8000_0000, 32'd1},
		{32'h5555_5555, 32'h0000_AAAA},
		{32'hAAAA_AAAA, 32'h0000_5555},
		{32'd40_000_000, 32'hFFFF_FFFF}
	};

	localparam int unsigned COMMON_RATES [9] = '{
		10_000, 20_000, 50_000, 100_000, 125_000, 250_000, 500_000, 800_000, 1_000_000
	};

	typedef struct packed {
		logic [DIV_W-1:0] clk_hz;
		logic [DIV_W-1:0] rate;
	} request_t;

	typedef struct packed {
		logic           valid;
		logic           no_fit;
		logic           range;
		logic [Q_W-1:0] quanta;
		logic [5:0]     prescaler;
		logic [3:0]     seg1;
		logic [2:0]     seg2;
	} bit_timing_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [DIV_W-1:0] source_clock = '0;
	logic [DIV_W-1:0] bit_rate = '0;
	logic             busy, done;
	logic             result_valid, no_fit, prescaler_out_of_range;
	logic [Q_W-1:0]   chosen_quanta;
	logic [5:0]       prescaler_value;
	logic [3:0]       phase_segment_one;
	logic [2:0]       phase_segment_two;

	request_t    request_q[$];
	bit_timing_t expected_timing_q[$];

	int unsigned errors = 0;
	int unsigned cycles = 0;
	int unsigned sent = 0;
	int unsigned idle_left = 0;
	int unsigned quiet_from = 0;
	int unsigned n_results = 0, n_zero = 0, n_nofit = 0, n_range = 0;
	logic [31:0] quanta_seen = '0;
	bit          accepted = 1'b0;

	can_bit_timing_calculator i_dut (
		.clk                    (clk),
		.arst_n                 (arst_n),
		.start                  (start),
		.busy                   (busy),
		.done                   (done),
		.source_clock           (source_clock),
		.bit_rate               (bit_rate),
		.result_valid           (result_valid),
		.no_fit                 (no_fit),
		.prescaler_out_of_range (prescaler_out_of_range),
		.chosen_quanta          (chosen_quanta),
		.prescaler_value        (prescaler_value),
		.phase_segment_one      (phase_segment_one),
		.phase_segment_two      (phase_segment_two)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Quanta search: first exact divisor from the top, else smallest remainder
	// below the rate, larger count kept on a tie.
	function automatic bit_timing_t calc_bit_timing(input logic [DIV_W-1:0] clk_hz,
			input logic [DIV_W-1:0] rate);
		bit_timing_t      t;
		logic [DIV_W-1:0] half, best_rem, rem, quot;
		int unsigned      n, pick;
		bit               hit;
		t = '0;
		if (clk_hz == 0 || rate == 0)
			return t;
		half = (clk_hz / rate) >> 1;
		best_rem = rate;
		pick = 0;
		hit = 1'b0;
		for (n = MAX_QUANTA; n >= MIN_QUANTA && !hit; n--) begin
			rem = half % n;
			if (rem == 0) begin
				pick = n;
				hit = 1'b1;
			end else if (rem < best_rem) begin
				best_rem = rem;
				pick = n;
			end
		end
		// no fit: prescaler taken from half itself
		quot = (pick != 0) ? half / pick : half;
		t.valid = 1'b1;
		t.no_fit = (pick == 0);
		if (quot == 0) begin
			t.prescaler = '0;
			t.range = 1'b1;
		end else if (quot - 1 > PRE_MAX) begin
			t.prescaler = 6'(PRE_MAX);
			t.range = 1'b1;
		end else begin
			t.prescaler = 6'(quot - 1);
		end
		t.quanta = Q_W'(pick);
		if (pick != 0) begin
			t.seg2 = 3'((pick - SYNC_Q) / 3);
			t.seg1 = 4'((pick - SYNC_Q) - (pick - SYNC_Q) / 3);
		end
		return t;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
			errors++;
		end
	endtask

	// driver: new transaction or idle at the falling edge
	always @(negedge clk) begin : drive_p
		logic     nxt_start;
		request_t req;
		nxt_start = start;
		if (arst_n) begin
			if (start && accepted)
				nxt_start = 1'b0;
			if (!nxt_start && request_q.size() > 0) begin
				if (idle_left > 0) begin
					idle_left--;
				end else if (!(sent == DRAIN_AT && expected_timing_q.size() != 0)) begin
					req = request_q.pop_front();
					source_clock <= req.clk_hz;
					bit_rate <= req.rate;
					nxt_start = 1'b1;
					sent++;
					if (sent < quiet_from && $urandom_range(0, 2) == 0)
						idle_left = $urandom_range(1, 18);
				end
			end
		end
		start <= nxt_start;
	end

	// monitor: take results, record accepted transactions
	always @(posedge clk) begin : check_p
		bit_timing_t want;
		accepted = 1'b0;
		if (arst_n) begin
			cycles++;
			if (done) begin
				if (expected_timing_q.size() == 0) begin
					$display("%0t: result with no transaction pending", $time);
					errors++;
				end else begin
					want = expected_timing_q.pop_front();
					check_field("result_valid", 32'(want.valid), 32'(result_valid));
					check_field("no_fit", 32'(want.no_fit), 32'(no_fit));
					check_field("prescaler_out_of_range", 32'(want.range),
						32'(prescaler_out_of_range));
					check_field("chosen_quanta", 32'(want.quanta), 32'(chosen_quanta));
					check_field("prescaler_value", 32'(want.prescaler),
						32'(prescaler_value));
					check_field("phase_segment_one", 32'(want.seg1),
						32'(phase_segment_one));
					check_field("phase_segment_two", 32'(want.seg2),
						32'(phase_segment_two));
					n_results++;
					if (!want.valid)
						n_zero++;
					if (want.no_fit)
						n_nofit++;
					if (want.range)
						n_range++;
					quanta_seen[want.quanta] = 1'b1;
				end
			end
			if (start && !busy) begin
				expected_timing_q.push_back(calc_bit_timing(source_clock, bit_rate));
				accepted = 1'b1;
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("%0t: timeout after %0d cycles", $time, cycles);
				$display("[can_bit_timing_calculator] ERROR");
				$finish;
			end
		end
	end

	initial begin
		request_t    req;
		logic [63:0] wide;
		int unsigned rate, half_req, kind;
		for (int i = 0; i < N_DIRECTED; i++)
			request_q.push_back(DIRECTED[i]);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 45) begin
				// realistic setup: rate times an achievable quanta*prescaler
				rate = ($urandom_range(0, 1) == 1) ? COMMON_RATES[$urandom_range(0, 8)]
					: $urandom_range(1, 2_000_000);
				half_req = $urandom_range(MIN_QUANTA, MAX_QUANTA) * $urandom_range(1, 70);
				if ($urandom_range(0, 3) == 0)
					half_req += $urandom_range(1, 24);
				wide = 64'(rate) * 64'(2 * half_req) + 64'($urandom_range(0, 2 * rate - 1));
				req.clk_hz = (wide > 64'hFFFF_FFFF) ? $urandom : wide[31:0];
				req.rate = rate;
			end else if (kind < 70) begin
				// tiny rates: no-fit and tie cases
				rate = $urandom_range(1, 8);
				half_req = $urandom_range(0, 3000);
				req.rate = rate;
				req.clk_hz = rate * 2 * half_req + $urandom_range(0, 2 * rate - 1);
			end else if (kind < 88) begin
				req.clk_hz = $urandom;
				req.rate = $urandom >> $urandom_range(0, 31);
			end else if (kind < 94) begin
				req.clk_hz = $urandom;
				req.rate = $urandom;
			end else begin
				req.clk_hz = ($urandom_range(0, 1) == 1) ? 32'd0 : $urandom;
				req.rate = (req.clk_hz == 0) ? $urandom : 32'd0;
			end
			request_q.push_back(req);
		end
		quiet_from = request_q.size() - QUIET_TAIL;

		repeat (9) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		while (request_q.size() != 0 || start || expected_timing_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("%0d transactions checked: %0d zero input, %0d no fit, %0d saturated",
			n_results, n_zero, n_nofit, n_range);
		$display("distinct quanta counts seen (0 = none): %0d", $countones(quanta_seen));
		if (errors == 0)
			$display("[can_bit_timing_calculator] OK");
		else
			$display("[can_bit_timing_calculator] ERROR");
		$finish;
	end

endmodule
